>>> hdl/fre_pkg.sv
package fre_pkg;

    // symbol space and ring limits
    localparam int SYMBOL_SPACE = 128;
    localparam int SYM_W = $clog2(SYMBOL_SPACE);
    localparam int MAX_WORD_LEN_DEF = 64;

    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE = 8'h7E;
    localparam logic [SYM_W-1:0] LEN_MAX = 7'd127;
    localparam logic [6:0] DIFF_MAX = 7'd127;
    localparam logic [12:0] SUM_MAX = 13'd8191;
    localparam logic [18:0] DIST_MAX = 19'h7FFFF;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_PAIR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOT_IN = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // pair request from the ring logic to the word accumulators
    typedef struct packed {
        logic upd;
        logic fin;
        logic same;
        logic both_in;
        logic [SYM_W-1:0] pa;
        logic [SYM_W-1:0] pb;
        logic [SYM_W-1:0] len;
    } pair_req_t;

    // word accumulator status back to the top level
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] steps;
        logic [6:0] diff;
        logic [12:0] sum;
        logic err;
        logic [18:0] distance;
    } word_stat_t;

    function automatic logic printable(input logic [7:0] s);
        printable = (s >= FIRST_PRINTABLE) && (s <= LAST_PRINTABLE);
    endfunction

endpackage

>>> hdl/flap_ring_distance_engine.sv
// flap ring distance engine
//
// input channel (in_valid/in_ready) carries one command per transfer:
// cmd, symbol_a, symbol_b and last_pair. clear empties the ring, append
// adds a printable symbol at the next ring slot, pair compares the
// current and target symbols and accumulates flap steps for the word.
// output channel (out_valid/out_ready) returns exactly one result per
// command; on the last pair of a word it carries the word distance and
// the word accumulators are cleared afterwards.
// the command is captured at the transfer and worked in the calc state;
// the output state loads the registered result. no new command is taken
// before that load, so the ring slot memory read and the accumulate stage
// are worked through in turn. the ring slots live in a 128-entry memory
// with a registered read; the membership bits sit in flops, cleared at once.
// reset clears the ring, the accumulators and the output valid at once.
// when the receiver stalls, the finished result waits in the output stage
// and no new command is taken until it has been loaded into the output
// register.
module flap_ring_distance_engine
    import fre_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  symbol_a,
    input  logic [7:0]  symbol_b,
    input  logic        last_pair,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  alphabet_size,
    output logic [6:0]  symbol_steps,
    output logic [6:0]  differing_count,
    output logic [12:0] step_sum,
    output logic [18:0] word_distance,
    output logic        word_done,
    output logic        word_error
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [SYMBOL_SPACE-1:0] member_reg, member_next;
    logic [SYM_W-1:0]        len_reg, len_next;
    logic [1:0]              op_status_reg, op_status_next;

    logic [1:0]              cmd_reg;
    logic [7:0]              a_reg;
    logic [7:0]              b_reg;
    logic                    last_reg;

    logic                    in_xfer;
    logic                    load;
    logic                    is_pair;
    logic                    done;
    logic                    append_ok;
    logic                    a_in;
    logic                    b_in;
    logic                    ram_we;
    logic [SYM_W-1:0]        pa;
    logic [SYM_W-1:0]        pb;
    pair_req_t               req;
    word_stat_t              stat;

    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [6:0]              size_reg;
    logic [6:0]              steps_reg;
    logic [6:0]              diff_reg;
    logic [12:0]             sum_reg;
    logic [18:0]             dist_reg;
    logic                    done_reg;
    logic                    err_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer = in_valid && in_ready;
    assign load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign is_pair = (cmd_reg == CMD_PAIR);
    assign done = is_pair && last_reg;

    // capture the command on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= cmd;
            a_reg <= symbol_a;
            b_reg <= symbol_b;
            last_reg <= last_pair;
        end
    end

    // ring slot memory, read at the transfer, used in the calc stage
    fre_ram #(
        .WIDTH(SYM_W),
        .DEPTH(SYMBOL_SPACE)
    ) u_ring_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (a_reg[SYM_W-1:0]),
        .wdata  (len_reg),
        .raddr0 (symbol_a[SYM_W-1:0]),
        .raddr1 (symbol_b[SYM_W-1:0]),
        .rdata0 (pa),
        .rdata1 (pb)
    );

    // membership lookups
    assign a_in = printable(a_reg) && member_reg[a_reg[SYM_W-1:0]];
    assign b_in = printable(b_reg) && member_reg[b_reg[SYM_W-1:0]];
    assign append_ok = printable(a_reg) && !member_reg[a_reg[SYM_W-1:0]]
                     && (len_reg != LEN_MAX);
    assign ram_we = (state_reg == S_CALC) && (cmd_reg == CMD_APPEND) && append_ok;

    // ring update and sequencing
    always_comb
    begin
        state_next = state_reg;
        member_next = member_reg;
        len_next = len_reg;
        op_status_next = op_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_OUT;
                op_status_next = ST_OK;
                case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        member_next = '0;
                        len_next = '0;
                    end
                    CMD_APPEND:
                    begin
                        if (append_ok)
                        begin
                            member_next[a_reg[SYM_W-1:0]] = 1'b1;
                            len_next = len_reg + SYM_W'(1);
                        end
                        else
                        begin
                            op_status_next = ST_IGNORED;
                        end
                    end
                    CMD_PAIR:
                    begin
                        op_status_next = ST_OK;
                    end
                    default:
                    begin
                        op_status_next = ST_IGNORED;
                    end
                endcase
            end
            S_OUT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            member_reg <= '0;
            len_reg <= '0;
            op_status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            member_reg <= member_next;
            len_reg <= len_next;
            op_status_reg <= op_status_next;
        end
    end

    // word accumulators
    always_comb
    begin
        req.upd = (state_reg == S_CALC) && is_pair;
        req.fin = load && done;
        req.same = (a_reg == b_reg);
        req.both_in = a_in && b_in;
        req.pa = pa;
        req.pb = pb;
        req.len = len_reg;
    end

    fre_word #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_word (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= is_pair ? stat.status : op_status_reg;
            size_reg <= len_reg;
            steps_reg <= is_pair ? stat.steps : 7'd0;
            diff_reg <= stat.diff;
            sum_reg <= stat.sum;
            dist_reg <= done ? stat.distance : 19'd0;
            done_reg <= done;
            err_reg <= stat.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign alphabet_size = size_reg;
    assign symbol_steps = steps_reg;
    assign differing_count = diff_reg;
    assign step_sum = sum_reg;
    assign word_distance = dist_reg;
    assign word_done = done_reg;
    assign word_error = err_reg;

endmodule

>>> hdl/fre_ram.sv
module fre_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> hdl/fre_word.sv
module fre_word
    import fre_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  pair_req_t  req,
    output word_stat_t stat
);

    localparam int PAIR_W = $clog2(MAX_WORD_LEN + 2);

    logic [12:0]       sum_reg, sum_next;
    logic [6:0]        diff_reg, diff_next;
    logic              err_reg, err_next;
    logic [PAIR_W-1:0] pairs_reg, pairs_next;
    logic [6:0]        steps_reg, steps_next;
    logic [1:0]        status_reg, status_next;

    logic              too_long;
    logic [SYM_W:0]    wrap;
    logic [6:0]        steps_calc;
    logic [13:0]       sum_add;
    logic [19:0]       prod;

    // forward flap steps between the two ring slots
    assign wrap = ({1'b0, req.pb} >= {1'b0, req.pa})
                ? ({1'b0, req.pb} - {1'b0, req.pa})
                : ({1'b0, req.pb} + {1'b0, req.len} - {1'b0, req.pa});
    assign steps_calc = wrap[6:0];
    assign sum_add = {1'b0, sum_reg} + {7'd0, steps_calc};
    assign too_long = pairs_reg >= PAIR_W'(MAX_WORD_LEN);

    // accumulator update
    always_comb
    begin
        sum_next = sum_reg;
        diff_next = diff_reg;
        err_next = err_reg;
        pairs_next = pairs_reg;
        steps_next = steps_reg;
        status_next = status_reg;
        if (req.fin)
        begin
            sum_next = '0;
            diff_next = '0;
            err_next = 1'b0;
            pairs_next = '0;
        end
        else if (req.upd)
        begin
            steps_next = '0;
            status_next = ST_OK;
            if (pairs_reg <= PAIR_W'(MAX_WORD_LEN))
            begin
                pairs_next = pairs_reg + PAIR_W'(1);
            end
            if (too_long)
            begin
                err_next = 1'b1;
                status_next = ST_TOO_LONG;
            end
            else if (!req.same)
            begin
                if (!req.both_in)
                begin
                    err_next = 1'b1;
                    status_next = ST_NOT_IN;
                end
                else
                begin
                    steps_next = steps_calc;
                    sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[12:0];
                    if (diff_reg != DIFF_MAX)
                    begin
                        diff_next = diff_reg + 7'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            diff_reg <= '0;
            err_reg <= 1'b0;
            pairs_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            diff_reg <= diff_next;
            err_reg <= err_next;
            pairs_reg <= pairs_next;
        end
    end

    // per-pair result, no reset needed
    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        status_reg <= status_next;
    end

    // word distance from the settled accumulators
    assign prod = {13'd0, diff_reg} * {7'd0, sum_reg};

    always_comb
    begin
        stat.status = status_reg;
        stat.steps = steps_reg;
        stat.diff = diff_reg;
        stat.sum = sum_reg;
        stat.err = err_reg;
        stat.distance = (prod > {1'b0, DIST_MAX}) ? DIST_MAX : prod[18:0];
    end

endmodule
